// ----- rtl/core/btha_pkg.sv -----
// Shared types and constants of the boundary-tag heap allocator.
// Used by btha_ctrl, btha_dp and boundary_tag_heap_allocator; no dependencies.
package btha_pkg;

	localparam logic [31:0] TAG_MASK  = 32'hFFFF_FFF8;
	localparam logic [31:0] MIN_BLOCK = 32'd16;
	localparam logic [31:0] INIT_BRK  = 32'd4112;
	localparam logic [16:0] CHUNK_RST = 17'd4096;
	localparam logic [16:0] LIMIT_RST = 17'd65536;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_IGN  = 2'd1;
	localparam logic [1:0] ST_OOM  = 2'd2;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic CFG_CHUNK = 1'b0;
	localparam logic CFG_LIMIT = 1'b1;

	typedef enum logic [5:0] {
		C_NOP, C_CLR, C_DEC, C_IGN,
		C_F_RD, C_F_W1, C_F_W2,
		C_M_RD1, C_M_RD2, C_M_RD3, C_M_RD4, C_M_RD5, C_M_EVAL,
		C_M_A1, C_M_A2, C_M_B1, C_M_B2, C_M_C1, C_M_C2, C_M_C3,
		C_FF_CHK, C_FF_EV, C_X_CHK, C_X_W2, C_X_W3,
		C_P_RD, C_P_EV, C_P_S2, C_P_S3, C_P_S4, C_P_N2, C_FIN
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic take;
		logic load_out;
	} ctl_t;

	typedef struct packed {
		logic is_free;
		logic ign;
		logic bp_gt_brk;
		logic ff_fit;
		logic ff_stop;
		logic pu;
		logic nu;
		logic oom;
		logic split;
		logic clr_last;
	} sts_t;

	// Contents of a word after reset: prologue, one 4096-byte free block, epilogue.
	function automatic logic [31:0] init_word(input logic [31:0] idx);
		logic [31:0] v;
		v = '0;
		if (idx == 32'd1 || idx == 32'd2) v = 32'd9;
		else if (idx == 32'd3 || idx == 32'd1026) v = 32'd4096;
		else if (idx == 32'd1027) v = 32'd1;
		return v;
	endfunction

endpackage

// ----- rtl/core/btha_ctrl.sv -----
// Sequencer of the heap allocator: walks the micro-op steps of each transaction.
// Depends on btha_pkg; drives btha_dp through ctl_t, reads sts_t.
module btha_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  btha_pkg::sts_t  sts,
	output btha_pkg::ctl_t  ctl
);

	typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_BUSY} state_t;

	state_t         state_q;
	btha_pkg::cmd_t cmd_q;
	logic           out_valid_q;
	logic           take;
	logic           load_out;
	btha_pkg::cmd_t merge_done;

	assign take      = in_valid && (state_q == S_IDLE);
	assign load_out  = (cmd_q == btha_pkg::C_FIN) && (!out_valid_q || out_ready);
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign ctl       = '{cmd: cmd_q, take: take, load_out: load_out};
	// after a merge, a free is finished; an allocate goes on to placement
	assign merge_done = sts.is_free ? btha_pkg::C_FIN : btha_pkg::C_P_RD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			cmd_q       <= btha_pkg::C_CLR;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out)       out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					if (sts.clr_last) begin
						state_q <= S_IDLE;
						cmd_q   <= btha_pkg::C_NOP;
					end
				end
				S_IDLE: begin
					if (take) begin
						state_q <= S_BUSY;
						cmd_q   <= btha_pkg::C_DEC;
					end
				end
				S_BUSY: begin
					unique case (cmd_q)
						btha_pkg::C_DEC: begin
							if (sts.ign)          cmd_q <= btha_pkg::C_IGN;
							else if (sts.is_free) cmd_q <= btha_pkg::C_F_RD;
							else                  cmd_q <= btha_pkg::C_FF_CHK;
						end
						btha_pkg::C_IGN:   cmd_q <= btha_pkg::C_FIN;
						btha_pkg::C_F_RD:  cmd_q <= btha_pkg::C_F_W1;
						btha_pkg::C_F_W1:  cmd_q <= btha_pkg::C_F_W2;
						btha_pkg::C_F_W2:  cmd_q <= btha_pkg::C_M_RD1;
						btha_pkg::C_M_RD1: cmd_q <= btha_pkg::C_M_RD2;
						btha_pkg::C_M_RD2: cmd_q <= btha_pkg::C_M_RD3;
						btha_pkg::C_M_RD3: cmd_q <= btha_pkg::C_M_RD4;
						btha_pkg::C_M_RD4: cmd_q <= btha_pkg::C_M_RD5;
						btha_pkg::C_M_RD5: cmd_q <= btha_pkg::C_M_EVAL;
						btha_pkg::C_M_EVAL: begin
							priority if (sts.pu && sts.nu) cmd_q <= merge_done;
							else if (sts.pu)               cmd_q <= btha_pkg::C_M_A1;
							else if (sts.nu)               cmd_q <= btha_pkg::C_M_B1;
							else                           cmd_q <= btha_pkg::C_M_C1;
						end
						btha_pkg::C_M_A1:  cmd_q <= btha_pkg::C_M_A2;
						btha_pkg::C_M_A2:  cmd_q <= merge_done;
						btha_pkg::C_M_B1:  cmd_q <= btha_pkg::C_M_B2;
						btha_pkg::C_M_B2:  cmd_q <= merge_done;
						btha_pkg::C_M_C1:  cmd_q <= btha_pkg::C_M_C2;
						btha_pkg::C_M_C2:  cmd_q <= btha_pkg::C_M_C3;
						btha_pkg::C_M_C3:  cmd_q <= merge_done;
						btha_pkg::C_FF_CHK: begin
							if (sts.bp_gt_brk) cmd_q <= btha_pkg::C_X_CHK;
							else               cmd_q <= btha_pkg::C_FF_EV;
						end
						btha_pkg::C_FF_EV: begin
							priority if (sts.ff_fit) cmd_q <= btha_pkg::C_P_RD;
							else if (sts.ff_stop)    cmd_q <= btha_pkg::C_X_CHK;
							else                     cmd_q <= btha_pkg::C_FF_CHK;
						end
						btha_pkg::C_X_CHK: begin
							if (sts.oom) cmd_q <= btha_pkg::C_FIN;
							else         cmd_q <= btha_pkg::C_X_W2;
						end
						btha_pkg::C_X_W2:  cmd_q <= btha_pkg::C_X_W3;
						btha_pkg::C_X_W3:  cmd_q <= btha_pkg::C_M_RD1;
						btha_pkg::C_P_RD:  cmd_q <= btha_pkg::C_P_EV;
						btha_pkg::C_P_EV: begin
							if (sts.split) cmd_q <= btha_pkg::C_P_S2;
							else           cmd_q <= btha_pkg::C_P_N2;
						end
						btha_pkg::C_P_S2:  cmd_q <= btha_pkg::C_P_S3;
						btha_pkg::C_P_S3:  cmd_q <= btha_pkg::C_P_S4;
						btha_pkg::C_P_S4:  cmd_q <= btha_pkg::C_FIN;
						btha_pkg::C_P_N2:  cmd_q <= btha_pkg::C_FIN;
						btha_pkg::C_FIN: begin
							if (load_out) begin
								state_q <= S_IDLE;
								cmd_q   <= btha_pkg::C_NOP;
							end
						end
						default: begin
							state_q <= S_IDLE;
							cmd_q   <= btha_pkg::C_NOP;
						end
					endcase
				end
				default: begin
					state_q <= S_IDLE;
					cmd_q   <= btha_pkg::C_NOP;
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/btha_dp.sv -----
// Datapath of the heap allocator: heap word memory, address registers, results.
// Depends on btha_pkg; commanded by btha_ctrl through ctl_t.
module btha_dp #(
	parameter int HEAP_BYTES = 65536
) (
	input  logic           clk,
	input  logic           arst_n,
	input  btha_pkg::ctl_t ctl,
	output btha_pkg::sts_t sts,
	input  logic           op,
	input  logic [16:0]    request_bytes,
	input  logic [15:0]    block_addr,
	input  logic           cfg_we,
	input  logic           cfg_index,
	input  logic [16:0]    cfg_data,
	output logic [15:0]    payload_addr,
	output logic [16:0]    granted_bytes,
	output logic [1:0]     status
);

	localparam int          Words = HEAP_BYTES / 4;
	localparam int          Aw    = $clog2(Words);
	localparam logic [31:0] HeapB = 32'(HEAP_BYTES);
	localparam logic [31:0] WordN = 32'(Words);

	logic [31:0] mem [Words];
	logic [31:0] mem_q;
	logic        rng_q;
	logic [Aw-1:0] clr_q;

	logic        op_q;
	logic [16:0] req_q;
	logic [15:0] addr_q;
	logic [31:0] bp_q, sz_q, prv_q, nxt_q, tp_q, tn_q, asz_q, csz_q, brk_q, pay_q, gr_q;
	logic [1:0]  st_q;
	logic        pu_q;
	logic [16:0] chunk_q, limit_q;

	logic [31:0] rd, rds, a, wd, word, ext, xsize, limit, asz_in, s_next;
	logic        we, re, inr, split_c, fit_c;

	assign rd   = rng_q ? mem_q : '0;
	assign rds  = rd & btha_pkg::TAG_MASK;
	assign word = a >> 2;
	assign inr  = word < WordN;

	assign ext     = (asz_q > {15'b0, chunk_q}) ? asz_q : {15'b0, chunk_q};
	assign xsize   = (((ext >> 2) + 32'd1) & 32'hFFFF_FFFE) << 2;
	assign limit   = ({15'b0, limit_q} > HeapB) ? HeapB : {15'b0, limit_q};
	assign split_c = (rds >= asz_q) && ((rds - asz_q) >= btha_pkg::MIN_BLOCK);
	assign fit_c   = !rd[0] && (asz_q <= rds);
	assign s_next  = bp_q + rds;
	assign asz_in  = (request_bytes <= 17'd8) ? btha_pkg::MIN_BLOCK
	               : (({15'b0, request_bytes} + 32'd15) & btha_pkg::TAG_MASK);

	assign sts.is_free   = (op_q == btha_pkg::OP_FREE);
	assign sts.ign       = (op_q == btha_pkg::OP_FREE) ? (addr_q == '0) : (req_q == '0);
	assign sts.bp_gt_brk = bp_q > brk_q;
	assign sts.ff_fit    = fit_c;
	assign sts.ff_stop   = (rds == '0) || (s_next <= bp_q);
	assign sts.pu        = pu_q;
	assign sts.nu        = rd[0];
	assign sts.oom       = (brk_q > limit) || (xsize > (limit - brk_q));
	assign sts.split     = split_c;
	assign sts.clr_last  = ({{(32-Aw){1'b0}}, clr_q} == WordN - 32'd1);

	always_comb begin
		a  = '0;
		wd = '0;
		we = 1'b0;
		re = 1'b0;
		unique case (ctl.cmd)
			btha_pkg::C_F_RD:   begin re = 1'b1; a = {16'b0, addr_q} - 32'd4; end
			btha_pkg::C_F_W1:   begin we = 1'b1; a = bp_q - 32'd4; wd = rds; end
			btha_pkg::C_F_W2:   begin we = 1'b1; a = bp_q + sz_q - 32'd8; wd = sz_q; end
			btha_pkg::C_M_RD1:  begin re = 1'b1; a = bp_q - 32'd4; end
			btha_pkg::C_M_RD2:  begin re = 1'b1; a = bp_q - 32'd8; end
			btha_pkg::C_M_RD3:  begin re = 1'b1; a = bp_q - rds - 32'd4; end
			btha_pkg::C_M_RD4:  begin re = 1'b1; a = prv_q + rds - 32'd8; end
			btha_pkg::C_M_RD5:  begin re = 1'b1; a = bp_q + sz_q - 32'd4; end
			btha_pkg::C_M_A1:   begin we = 1'b1; a = bp_q - 32'd4; wd = sz_q + tn_q; end
			btha_pkg::C_M_A2:   begin we = 1'b1; a = bp_q + sz_q - 32'd8; wd = sz_q; end
			btha_pkg::C_M_B1:   begin we = 1'b1; a = bp_q + sz_q - 32'd8; wd = sz_q + tp_q; end
			btha_pkg::C_M_B2:   begin we = 1'b1; a = prv_q - 32'd4; wd = sz_q + tp_q; end
			btha_pkg::C_M_C1:   begin re = 1'b1; a = nxt_q + tn_q - 32'd8; end
			btha_pkg::C_M_C2:   begin we = 1'b1; a = prv_q - 32'd4; wd = sz_q + tp_q + rds; end
			btha_pkg::C_M_C3:   begin we = 1'b1; a = nxt_q + tn_q - 32'd8; wd = sz_q; end
			btha_pkg::C_FF_CHK: begin re = 1'b1; a = bp_q - 32'd4; end
			btha_pkg::C_X_CHK:  begin we = !sts.oom; a = brk_q - 32'd4; wd = xsize; end
			btha_pkg::C_X_W2:   begin we = 1'b1; a = bp_q + sz_q - 32'd8; wd = sz_q; end
			btha_pkg::C_X_W3:   begin we = 1'b1; a = bp_q + sz_q - 32'd4; wd = 32'd1; end
			btha_pkg::C_P_RD:   begin re = 1'b1; a = bp_q - 32'd4; end
			btha_pkg::C_P_EV: begin
				we = 1'b1;
				a  = bp_q - 32'd4;
				wd = split_c ? (asz_q | 32'd1) : (rds | 32'd1);
			end
			btha_pkg::C_P_S2:   begin we = 1'b1; a = bp_q + asz_q - 32'd8; wd = asz_q | 32'd1; end
			btha_pkg::C_P_S3:   begin we = 1'b1; a = bp_q + asz_q - 32'd4; wd = csz_q - asz_q; end
			btha_pkg::C_P_S4:   begin we = 1'b1; a = bp_q + csz_q - 32'd8; wd = csz_q - asz_q; end
			btha_pkg::C_P_N2:   begin we = 1'b1; a = bp_q + csz_q - 32'd8; wd = csz_q | 32'd1; end
			default: ;
		endcase
	end

	// heap memory: one access per cycle, registered read
	always_ff @(posedge clk) begin
		if (ctl.cmd == btha_pkg::C_CLR)
			mem[clr_q] <= btha_pkg::init_word({{(32-Aw){1'b0}}, clr_q});
		else if (we && inr)
			mem[word[Aw-1:0]] <= wd;
		if (re) begin
			mem_q <= mem[word[Aw-1:0]];
			rng_q <= inr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			brk_q   <= btha_pkg::INIT_BRK;
			chunk_q <= btha_pkg::CHUNK_RST;
			limit_q <= btha_pkg::LIMIT_RST;
		end else begin
			if (ctl.cmd == btha_pkg::C_CLR) clr_q <= clr_q + Aw'(1);
			if (cfg_we) begin
				if (cfg_index == btha_pkg::CFG_CHUNK) chunk_q <= cfg_data;
				else                                  limit_q <= cfg_data;
			end
			if (ctl.cmd == btha_pkg::C_X_CHK && !sts.oom) brk_q <= brk_q + xsize;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			op_q   <= op;
			req_q  <= request_bytes;
			addr_q <= block_addr;
			asz_q  <= asz_in;
			bp_q   <= 32'd8;
			pay_q  <= '0;
			gr_q   <= '0;
			st_q   <= btha_pkg::ST_DONE;
		end
		unique case (ctl.cmd)
			btha_pkg::C_IGN:    st_q <= btha_pkg::ST_IGN;
			btha_pkg::C_F_RD:   bp_q <= {16'b0, addr_q};
			btha_pkg::C_F_W1:   begin sz_q <= rds; gr_q <= rds; end
			btha_pkg::C_M_RD2:  sz_q <= rds;
			btha_pkg::C_M_RD3:  prv_q <= bp_q - rds;
			btha_pkg::C_M_RD4:  tp_q <= rds;
			btha_pkg::C_M_RD5:  begin pu_q <= rd[0]; nxt_q <= bp_q + sz_q; end
			btha_pkg::C_M_EVAL: tn_q <= rds;
			btha_pkg::C_M_A1:   sz_q <= sz_q + tn_q;
			btha_pkg::C_M_B2:   bp_q <= prv_q;
			btha_pkg::C_M_C2:   sz_q <= sz_q + tp_q + rds;
			btha_pkg::C_M_C3:   bp_q <= prv_q;
			btha_pkg::C_FF_EV:  if (!fit_c) bp_q <= s_next;
			btha_pkg::C_X_CHK: begin
				if (sts.oom) st_q <= btha_pkg::ST_OOM;
				else begin
					bp_q <= brk_q;
					sz_q <= xsize;
				end
			end
			btha_pkg::C_P_EV: begin
				csz_q <= rds;
				pay_q <= bp_q;
				gr_q  <= split_c ? asz_q : rds;
			end
			default: ;
		endcase
		if (ctl.load_out) begin
			payload_addr  <= pay_q[15:0];
			granted_bytes <= gr_q[16:0];
			status        <= st_q;
		end
	end

endmodule

// ----- rtl/core/boundary_tag_heap_allocator.sv -----
// Top level of the boundary-tag heap allocator (implicit list, first fit).
// Depends on btha_pkg, btha_ctrl and btha_dp.
//
//  channel  signals                                         direction
//  in       in_valid/in_ready, op, request_bytes, block_addr  request in
//  out      out_valid/out_ready, payload_addr, granted_bytes, status  result out
//  cfg      cfg_we, cfg_index, cfg_data                       register write
//
// Steps after acceptance: an ignored request decodes and finishes; a free
//   rewrites its tags and merges; an allocate walks the first-fit search
//   block by block and places; a failed search grows the heap and merges
//   first; out of memory ends the walk. A request is taken only after the
//   last one leaves its final step. The single heap memory port allows one tag access per cycle.
// Reset: arst_n clears control; a clearing pass over every heap word then
//   rebuilds the initial heap, with in_ready low throughout.
// Stalls: a finished result waits in the output register; a new transaction
//   is taken meanwhile and holds only at its last step until the slot frees.
module boundary_tag_heap_allocator #(
	parameter int HEAP_BYTES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [16:0] request_bytes,
	input  logic [15:0] block_addr,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] payload_addr,
	output logic [16:0] granted_bytes,
	output logic [1:0]  status,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [16:0] cfg_data
);

	btha_pkg::ctl_t ctl;
	btha_pkg::sts_t sts;

	// sequencer
	btha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	// heap memory, tag arithmetic and result registers
	btha_dp #(
		.HEAP_BYTES (HEAP_BYTES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.sts           (sts),
		.op            (op),
		.request_bytes (request_bytes),
		.block_addr    (block_addr),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.payload_addr  (payload_addr),
		.granted_bytes (granted_bytes),
		.status        (status)
	);

endmodule

// ----- tb/boundary_tag_heap_allocator_tb.sv -----
// Self-checking testbench for boundary_tag_heap_allocator: mixed allocate/free traffic,
// predicted by an in-bench heap image, checked result by result. Depends on btha_pkg.
`timescale 1ns / 100ps

module boundary_tag_heap_allocator_tb;

	localparam int HEAP_BYTES = 65536;
	localparam int HEAP_WORDS = HEAP_BYTES / 4;
	localparam int WDOG_LIMIT = 200000;

	typedef struct {
		logic        op;
		logic [16:0] req;
		logic [15:0] addr;
	} heap_req_t;

	typedef struct {
		logic [15:0] pay;
		logic [16:0] granted;
		logic [1:0]  st;
	} heap_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        op = btha_pkg::OP_ALLOC;
	logic [16:0] request_bytes = '0;
	logic [15:0] block_addr = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] payload_addr;
	logic [16:0] granted_bytes;
	logic [1:0]  status;
	logic        cfg_we = 1'b0;
	logic        cfg_index = btha_pkg::CFG_CHUNK;
	logic [16:0] cfg_data = '0;

	// heap image and registers as the block should hold them
	logic [31:0] heap_img [HEAP_WORDS];
	logic [31:0] brk_img;
	logic [31:0] chunk_img;
	logic [31:0] limit_img;

	heap_req_t   pending_reqs[$];
	heap_res_t   expected_res[$];
	logic [15:0] live_blocks[$];

	int errors = 0;
	int idle_in_pct = 0;
	int stall_out_pct = 0;
	int quiet_cycles = 0;

	boundary_tag_heap_allocator #(.HEAP_BYTES(HEAP_BYTES)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .request_bytes(request_bytes), .block_addr(block_addr),
		.out_valid(out_valid), .out_ready(out_ready),
		.payload_addr(payload_addr), .granted_bytes(granted_bytes), .status(status),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ---------------- heap image access (word addressed, wraps at 32 bits)
	function automatic logic [31:0] peek(input logic [31:0] a);
		logic [31:0] i;
		i = a >> 2;
		return (i < HEAP_WORDS) ? heap_img[i] : 32'd0;
	endfunction

	function automatic void poke(input logic [31:0] a, input logic [31:0] v);
		logic [31:0] i;
		i = a >> 2;
		if (i < HEAP_WORDS)
			heap_img[i] = v;
	endfunction

	function automatic logic [31:0] sz(input logic [31:0] a);
		return peek(a) & btha_pkg::TAG_MASK;
	endfunction

	function automatic logic used(input logic [31:0] a);
		logic [31:0] v;
		v = peek(a);
		return v[0];
	endfunction

	// merge a just-freed block with free neighbours; returns new payload pointer
	function automatic logic [31:0] coalesce(input logic [31:0] bp);
		logic [31:0] size, prv, nxt, nf;
		logic pu, nu;
		size = sz(bp - 4);
		prv  = bp - sz(bp - 8);
		nxt  = bp + size;
		pu   = used(prv + sz(prv - 4) - 8);
		nu   = used(nxt - 4);
		if (pu && nu)
			return bp;
		if (pu) begin
			size += sz(nxt - 4);
			poke(bp - 4, size);
			poke(bp + size - 8, size);
			return bp;
		end
		if (nu) begin
			size += sz(prv - 4);
			poke(bp + sz(bp - 4) - 8, size);
			poke(prv - 4, size);
			return prv;
		end
		size += sz(prv - 4);
		size += sz(nxt + sz(nxt - 4) - 8);
		nf = nxt + sz(nxt - 4) - 8;
		poke(prv - 4, size);
		poke(nf, size);
		return prv;
	endfunction

	function automatic logic [31:0] carve(input logic [31:0] bp, input logic [31:0] asize);
		logic [31:0] csize;
		csize = sz(bp - 4);
		if (csize >= asize && csize - asize >= btha_pkg::MIN_BLOCK) begin
			poke(bp - 4, asize | 32'd1);
			poke(bp + asize - 8, asize | 32'd1);
			poke(bp + asize - 4, csize - asize);
			poke(bp + csize - 8, csize - asize);
			return asize;
		end
		poke(bp - 4, csize | 32'd1);
		poke(bp + csize - 8, csize | 32'd1);
		return csize;
	endfunction

	// first-fit walk from the prologue; 0 when nothing fits or the list is broken
	function automatic logic [31:0] first_fit_walk(input logic [31:0] asize);
		logic [31:0] bp, s, nx;
		bp = 32'd8;
		while (bp <= brk_img) begin
			s = sz(bp - 4);
			if (s == 0)
				return 0;
			if (!used(bp - 4) && asize <= s)
				return bp;
			nx = bp + s;
			if (nx <= bp)
				return 0;
			bp = nx;
		end
		return 0;
	endfunction

	function automatic heap_res_t heap_predict(input heap_req_t r);
		heap_res_t res;
		logic [31:0] s, asize, bp, ext, grow, lim, pay, gr;
		logic [1:0] st;
		pay = 0;
		gr  = 0;
		st  = btha_pkg::ST_DONE;
		if (r.op == btha_pkg::OP_FREE) begin
			if (r.addr == 0) begin
				st = btha_pkg::ST_IGN;
			end else begin
				bp = {16'd0, r.addr};
				s  = sz(bp - 4);
				poke(bp - 4, s);
				poke(bp + sz(bp - 4) - 8, s);
				void'(coalesce(bp));
				gr = s;
			end
		end else if (r.req == 0) begin
			st = btha_pkg::ST_IGN;
		end else begin
			asize = (r.req <= 8) ? btha_pkg::MIN_BLOCK : ((({15'd0, r.req}) + 15) / 8) * 8;
			bp = first_fit_walk(asize);
			if (bp == 0) begin
				ext  = (asize > chunk_img) ? asize : chunk_img;
				grow = (((ext >> 2) + 1) & ~32'd1) * 4;
				lim  = (limit_img > HEAP_BYTES) ? HEAP_BYTES : limit_img;
				if (brk_img > lim || grow > lim - brk_img) begin
					st = btha_pkg::ST_OOM;
				end else begin
					bp = brk_img;
					brk_img += grow;
					poke(bp - 4, grow);
					poke(bp + grow - 8, grow);
					poke(bp + grow - 4, 32'd1);
					bp = coalesce(bp);
				end
			end
			if (st == btha_pkg::ST_DONE) begin
				gr  = carve(bp, asize);
				pay = bp;
			end
		end
		res.pay     = pay[15:0];
		res.granted = gr[16:0];
		res.st      = st;
		return res;
	endfunction

	// predict, queue the transaction and its result, keep the list of live blocks
	task automatic issue(input logic o, input logic [16:0] rq, input logic [15:0] ad);
		heap_req_t r;
		heap_res_t e;
		r.op = o; r.req = rq; r.addr = ad;
		e = heap_predict(r);
		if (o == btha_pkg::OP_ALLOC && e.st == btha_pkg::ST_DONE)
			live_blocks.push_back(e.pay);
		pending_reqs.push_back(r);
		expected_res.push_back(e);
	endtask

	task automatic free_live(input int idx);
		logic [15:0] a;
		a = live_blocks[idx];
		live_blocks.delete(idx);
		issue(btha_pkg::OP_FREE, 17'($urandom), a);
	endtask

	// mostly well-formed traffic; noisy frees only when asked
	task automatic random_item(input int noise_pct);
		int pick;
		logic [16:0] rq;
		pick = $urandom_range(99);
		if (pick < noise_pct) begin
			issue(btha_pkg::OP_FREE, 17'($urandom), 16'($urandom));
		end else if (live_blocks.size() > 0 && pick < 47) begin
			free_live($urandom_range(live_blocks.size() - 1));
		end else begin
			case ($urandom_range(9))
				0:       rq = 17'($urandom_range(8));
				1:       rq = 17'($urandom_range(65536));
				2, 3:    rq = 17'($urandom_range(4096));
				default: rq = 17'($urandom_range(1, 256));
			endcase
			issue(btha_pkg::OP_ALLOC, rq, 16'($urandom));
		end
	endtask

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || in_valid || expected_res.size() != 0)
			@(posedge clk);
		// allow the block to settle before any register write
		repeat (40) @(posedge clk);
	endtask

	task automatic write_regs(input logic [16:0] chunk, input logic [16:0] lim);
		@(posedge clk);
		cfg_we <= 1'b1; cfg_index <= btha_pkg::CFG_CHUNK; cfg_data <= chunk;
		@(posedge clk);
		cfg_index <= btha_pkg::CFG_LIMIT; cfg_data <= lim;
		@(posedge clk);
		cfg_we <= 1'b0;
		chunk_img = {15'd0, chunk};
		limit_img = {15'd0, lim};
	endtask

	task automatic set_idling(input int mode);
		case (mode % 4)
			0: begin idle_in_pct = 0;  stall_out_pct = 0;  end
			1: begin idle_in_pct = 60; stall_out_pct = 0;  end
			2: begin idle_in_pct = 0;  stall_out_pct = 60; end
			default: begin idle_in_pct = 18; stall_out_pct = 18; end
		endcase
	endtask

	// ---------------- driver: input channel
	always @(posedge clk) begin
		if (!in_valid || in_ready) begin
			if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_in_pct) begin
				in_valid      <= 1'b1;
				op            <= pending_reqs[0].op;
				request_bytes <= pending_reqs[0].req;
				block_addr    <= pending_reqs[0].addr;
				void'(pending_reqs.pop_front());
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= ($urandom_range(99) >= stall_out_pct);
	end

	// ---------------- monitor: result channel
	always @(posedge clk) begin
		heap_res_t e;
		if (out_valid && out_ready) begin
			if (expected_res.size() == 0) begin
				$display("%0t: unexpected result pay=%h granted=%h status=%0d",
					$time, payload_addr, granted_bytes, status);
				errors++;
			end else begin
				e = expected_res.pop_front();
				if (payload_addr !== e.pay) begin
					$display("%0t: payload_addr exp %h got %h", $time, e.pay, payload_addr);
					errors++;
				end
				if (granted_bytes !== e.granted) begin
					$display("%0t: granted_bytes exp %h got %h", $time, e.granted,
						granted_bytes);
					errors++;
				end
				if (status !== e.st) begin
					$display("%0t: status exp %0d got %0d", $time, e.st, status);
					errors++;
				end
			end
		end
	end

	// ---------------- watchdog: no transaction on either channel for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// ---------------- stimulus
	initial begin
		int ph;
		heap_img = '{default: 32'd0};
		heap_img[1] = 32'd9; heap_img[2] = 32'd9;
		heap_img[3] = 32'd4096; heap_img[1026] = 32'd4096; heap_img[1027] = 32'd1;
		brk_img = 32'd4112; chunk_img = 32'd4096; limit_img = 32'd65536;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: sizes at the edges, ignored requests, merges, growth, out of memory
		issue(btha_pkg::OP_ALLOC, 17'd0, 16'hFFFF);      // zero size ignored
		issue(btha_pkg::OP_FREE, 17'h1FFFF, 16'd0);      // null free ignored
		issue(btha_pkg::OP_ALLOC, 17'd1, 16'd0);
		issue(btha_pkg::OP_ALLOC, 17'd8, 16'd0);
		issue(btha_pkg::OP_ALLOC, 17'd9, 16'd0);
		issue(btha_pkg::OP_ALLOC, 17'd24, 16'd0);
		free_live(1);                                    // hole between two used blocks
		free_live(0);                                    // merges with following hole
		issue(btha_pkg::OP_ALLOC, 17'd16, 16'd0);        // first fit reuses the hole
		issue(btha_pkg::OP_ALLOC, 17'd4000, 16'd0);      // fits the last free block exactly, no growth
		issue(btha_pkg::OP_ALLOC, 17'd65536, 16'd0);     // largest request: out of memory
		issue(btha_pkg::OP_ALLOC, 17'd20000, 16'd0);
		issue(btha_pkg::OP_ALLOC, 17'd30000, 16'd0);
		while (live_blocks.size() != 0)
			free_live(live_blocks.size() - 1);
		issue(btha_pkg::OP_ALLOC, 17'd4072, 16'd0);      // first fit splits the merged free block
		free_live(0);
		set_idling(0);
		wait_drained();

		// each phase: register setting, idling pattern, random traffic
		for (ph = 0; ph < 8; ph++) begin
			case (ph)
				0: write_regs(17'd8, 17'd4112);        // smallest chunk, limit below break
				1: write_regs(17'd65536, 17'd65536);   // chunk equal to the memory size
				2: write_regs(17'd13, 17'd20000);      // chunk not a multiple of 8
				3: write_regs(17'h1FFFF, 17'h1FFFF);   // limit above memory size
				4: write_regs(17'd4096, 17'd65536);
				5: write_regs(17'd64, 17'd40000);
				6: write_regs(17'd8, 17'd65536);
				default: write_regs(17'd1024, 17'd65536);
			endcase
			set_idling(ph);
			// a few stray frees only at the very end: they may wreck the block list
			repeat (185) random_item(ph == 7 ? 4 : 0);
			wait_drained();
		end

		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
